### src/ftrb_pkg.sv
// Shared types and constants for the framed transmit ring buffer.
// Depends on nothing; ftrb_front, ftrb_back, the top, the checker and the testbench import it.
package ftrb_pkg;

  localparam int OP_W   = 2;
  localparam int FLEN_W = 9;
  localparam int BYTE_W = 8;

  localparam int QUEUE_BYTES_DEF = 256;
  localparam int CHUNK_MAX_DEF   = 16;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA   = 2'd1;
  localparam logic [OP_W-1:0] OP_TXDONE = 2'd2;

  localparam logic RES_ANSWER = 1'b0;
  localparam logic RES_BYTE   = 1'b1;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_TXDONE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [FLEN_W-1:0] flen;
    logic [BYTE_W-1:0] dbyte;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic              accepted;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
  } res_t;

endpackage

### src/ftrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ftrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### src/ftrb_fifo.sv
// Small register queue used for the command queue and the result queue.
// Depends on nothing.
module ftrb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             wr_fire, rd_fire;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign wr_fire = wr && !full;
  assign rd_fire = rd && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_fire) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (rd_fire) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (wr_fire && !rd_fire) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (rd_fire && !wr_fire) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

### src/ftrb_front.sv
// Front end: takes input words, decodes the operation and queues commands.
// Depends on ftrb_pkg.
module ftrb_front (
  input  logic                       push,
  output logic                       full,
  input  logic [ftrb_pkg::OP_W-1:0]   in_operation,
  input  logic [ftrb_pkg::FLEN_W-1:0] in_frame_length,
  input  logic [ftrb_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       cmd_full,
  output logic                       cmd_wr,
  output ftrb_pkg::cmd_t             cmd
);
  import ftrb_pkg::*;

  logic known;

  assign full = cmd_full;

  always_comb begin
    known      = 1'b1;
    cmd.kind   = CMD_APPEND;
    cmd.flen   = in_frame_length;
    cmd.dbyte  = in_data_byte;
    unique case (in_operation)
      OP_APPEND: cmd.kind = CMD_APPEND;
      OP_DATA:   cmd.kind = CMD_DATA;
      OP_TXDONE: cmd.kind = CMD_TXDONE;
      default:   known = 1'b0;
    endcase
  end

  // Unused operation codes are accepted and dropped here.
  assign cmd_wr = push && !cmd_full && known;

endmodule

### src/ftrb_back.sv
// Back end: pointer bookkeeping, byte store and chunk emission.
// Depends on ftrb_pkg and ftrb_ram.
module ftrb_back #(
  parameter int QUEUE_BYTES = ftrb_pkg::QUEUE_BYTES_DEF,
  parameter int CHUNK_MAX   = ftrb_pkg::CHUNK_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  ftrb_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output ftrb_pkg::res_t res
);
  import ftrb_pkg::*;

  localparam int AW = $clog2(QUEUE_BYTES);
  localparam int CW = $clog2(CHUNK_MAX + 1);
  localparam int LW = ((AW > FLEN_W) ? AW : FLEN_W) + 1;
  localparam logic [LW-1:0] QB  = LW'(QUEUE_BYTES);
  localparam logic [LW-1:0] CM  = LW'(CHUNK_MAX);
  localparam logic [LW-1:0] ONE = LW'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADV  = 5'b00010,
    S_CALC = 5'b00100,
    S_RD   = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt, ea_r, ea_nxt;
  logic [CW-1:0]     infl_r, infl_nxt, k_r, k_nxt;
  logic [FLEN_W-1:0] pend_r, pend_nxt, total_r, total_nxt;
  logic              facc_r, facc_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [LW-1:0]     free_s, len_s;
  logic              fits, now_empty, last_byte;
  logic [FLEN_W-1:0] offset;

  function automatic logic [AW-1:0] wrap_f(input logic [LW-1:0] s);
    logic [LW-1:0] r;
    r = (s >= QB) ? s - QB : s;
    return r[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_f(input logic [LW-1:0] n);
    logic [LW-1:0] r;
    r = (n > CM) ? CM : n;
    return r[CW-1:0];
  endfunction

  ftrb_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (cmd.dbyte),
    .rd_en   (ram_re),
    .rd_addr (ea_r),
    .rd_data (ram_rdata)
  );

  // One slot always stays empty, so equal pointers mean an empty queue.
  assign free_s = (rp_r > wp_r) ? LW'(rp_r) - LW'(wp_r) - ONE
                                : QB + LW'(rp_r) - LW'(wp_r) - ONE;
  assign fits      = LW'(cmd.flen) <= free_s;
  assign now_empty = (rp_r == wp_r);
  assign offset    = total_r - pend_r;
  assign ram_waddr = wrap_f(LW'(wp_r) + LW'(offset));
  assign len_s     = (rp_r == wp_r) ? '0
                   : (rp_r > wp_r)  ? QB - LW'(rp_r)
                   :                  LW'(wp_r) - LW'(rp_r);
  assign last_byte = ((CW+1)'(k_r) + (CW+1)'(1)) == (CW+1)'(infl_r);

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    ea_nxt    = ea_r;
    infl_nxt  = infl_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    facc_nxt  = facc_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_push  = 1'b0;
    res       = '{kind: RES_ANSWER, accepted: 1'b0, tx_byte: '0, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_APPEND: begin
              if (!res_full) begin
                cmd_pop      = 1'b1;
                res_push     = 1'b1;
                res.accepted = fits;
                total_nxt    = fits ? cmd.flen : '0;
                pend_nxt     = fits ? cmd.flen : '0;
                facc_nxt     = fits && (cmd.flen != '0);
              end
            end
            CMD_DATA: begin
              cmd_pop = 1'b1;
              if (facc_r && pend_r != '0) begin
                ram_we   = 1'b1;
                pend_nxt = pend_r - FLEN_W'(1);
                if (pend_r == FLEN_W'(1)) begin
                  facc_nxt = 1'b0;
                  wp_nxt   = wrap_f(LW'(wp_r) + LW'(total_r));
                  if (now_empty) begin
                    infl_nxt  = clamp_f(LW'(total_r));
                    ea_nxt    = rp_r;
                    k_nxt     = '0;
                    state_nxt = S_RD;
                  end
                end
              end
            end
            CMD_TXDONE: begin
              cmd_pop   = 1'b1;
              state_nxt = S_ADV;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      S_ADV: begin
        rp_nxt    = wrap_f(LW'(rp_r) + LW'(infl_r));
        state_nxt = S_CALC;
      end
      S_CALC: begin
        infl_nxt  = clamp_f(len_s);
        ea_nxt    = rp_r;
        k_nxt     = '0;
        state_nxt = (len_s == '0) ? S_IDLE : S_RD;
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!res_full) begin
          res_push    = 1'b1;
          res.kind    = RES_BYTE;
          res.tx_byte = ram_rdata;
          res.last    = last_byte;
          if (last_byte) begin
            state_nxt = S_IDLE;
          end else begin
            ea_nxt    = wrap_f(LW'(ea_r) + ONE);
            k_nxt     = k_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      infl_r  <= '0;
      pend_r  <= '0;
      total_r <= '0;
      facc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      infl_r  <= infl_nxt;
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
      facc_r  <= facc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r <= ea_nxt;
    k_r  <= k_nxt;
  end

endmodule

### src/framed_tx_ring_buffer_core.sv
// Top level of the framed transmit ring buffer.
// Depends on ftrb_pkg, ftrb_front, ftrb_fifo and ftrb_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------------
//   input    | push / full      | in_operation, in_frame_length, in_data_byte
//   result   | empty / pop      | out_result_kind, out_accepted, out_tx_byte, out_last
//
// A word enters a two-entry command queue; in its idle state the back end takes
// an append start or a data byte, and a transmit done passes through the advance
// and recalculate states; each byte sent takes a store read, then a result write,
// set by the single read port of the byte store. Results wait in a two-entry queue.
// Reset is synchronous and needs no clearing pass. full rises while two
// commands wait; results that are not popped stall appends and byte output in
// the back end, and the input once the command queue has filled.
module framed_tx_ring_buffer_core #(
  parameter int QUEUE_BYTES = ftrb_pkg::QUEUE_BYTES_DEF,
  parameter int CHUNK_MAX   = ftrb_pkg::CHUNK_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [ftrb_pkg::OP_W-1:0]   in_operation,
  input  logic [ftrb_pkg::FLEN_W-1:0] in_frame_length,
  input  logic [ftrb_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_result_kind,
  output logic                       out_accepted,
  output logic [ftrb_pkg::BYTE_W-1:0] out_tx_byte,
  output logic                       out_last
);
  import ftrb_pkg::*;

  cmd_t                cmd_in, cmd_out;
  res_t                res_in, res_out;
  logic                cmd_wr, cmd_full, cmd_empty, cmd_pop;
  logic                res_push, res_full;
  logic [$bits(cmd_t)-1:0] cmd_vec;
  logic [$bits(res_t)-1:0] res_vec;

  ftrb_front u_front (
    .push            (push),
    .full            (full),
    .in_operation    (in_operation),
    .in_frame_length (in_frame_length),
    .in_data_byte    (in_data_byte),
    .cmd_full        (cmd_full),
    .cmd_wr          (cmd_wr),
    .cmd             (cmd_in)
  );

  ftrb_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_data (cmd_vec),
    .empty   (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_vec);

  ftrb_back #(.QUEUE_BYTES(QUEUE_BYTES), .CHUNK_MAX(CHUNK_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ftrb_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_vec),
    .empty   (empty)
  );

  assign res_out         = res_t'(res_vec);
  assign out_result_kind = res_out.kind;
  assign out_accepted    = res_out.accepted;
  assign out_tx_byte     = res_out.tx_byte;
  assign out_last        = res_out.last;

endmodule

### src/ftrb_checker.sv
// Port-level checks for the framed transmit ring buffer, bound to the top.
// Depends on ftrb_pkg and framed_tx_ring_buffer_core.
module ftrb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic                       out_result_kind,
  input logic                       out_accepted,
  input logic [ftrb_pkg::BYTE_W-1:0] out_tx_byte,
  input logic                       out_last
);
  import ftrb_pkg::*;

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // An append answer is always a single word with a zero byte field.
  a_answer_form: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_result_kind == RES_ANSWER |-> out_last && out_tx_byte == '0)
    else $error("malformed append answer");

  // Bytes handed to the transmitter never carry an accept flag.
  a_byte_form: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_result_kind == RES_BYTE |-> !out_accepted)
    else $error("byte word with accept flag");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_tx_byte) && $stable(out_result_kind))
    else $error("waiting result changed");

endmodule

bind framed_tx_ring_buffer_core ftrb_checker u_ftrb_checker (.*);

### test/framed_tx_ring_buffer_core_tb.sv
// Self-checking testbench for framed_tx_ring_buffer_core: frame appends, data bytes and
// transmit-done words are predicted by a ring tracker and every result word is compared.
// Depends on ftrb_pkg and the block's RTL.
module framed_tx_ring_buffer_core_tb;
  import ftrb_pkg::*;

  localparam int QB = QUEUE_BYTES_DEF;
  localparam int CM = CHUNK_MAX_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class ring_tracker;
    logic [BYTE_W-1:0] store [QB];
    int wr_ptr, rd_ptr, flight, bytes_left, frame_len;
    bit frame_open, was_empty;
    res_t expected_q[$];
    int errors, words_in, answers, tx_bytes;

    function new();
      foreach (store[i]) store[i] = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      flight = 0;
      bytes_left = 0;
      frame_len = 0;
      frame_open = 0;
      was_empty = 0;
      errors = 0;
      words_in = 0;
      answers = 0;
      tx_bytes = 0;
    endfunction

    function int free_bytes();
      int d = (rd_ptr + QB - wr_ptr) % QB;
      if (d == 0) d = QB;
      return d - 1;
    endfunction

    function int backlog();
      return (wr_ptr + QB - rd_ptr) % QB;
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction

    function void send_chunk();
      for (int k = 0; k < flight; k++)
        expected_q.push_back(res_t'{RES_BYTE, 1'b0, store[(rd_ptr + k) % QB], k == flight - 1});
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [FLEN_W-1:0] flen,
                            logic [BYTE_W-1:0] dbyte);
      bit fits;
      int len;
      words_in++;
      case (op)
        OP_APPEND: begin
          fits = (flen <= free_bytes());
          was_empty = (rd_ptr == wr_ptr);
          frame_len = fits ? int'(flen) : 0;
          bytes_left = frame_len;
          frame_open = fits && flen != 0;
          expected_q.push_back(res_t'{RES_ANSWER, fits, 8'h00, 1'b1});
        end
        OP_DATA: begin
          if (frame_open && bytes_left != 0) begin
            store[(wr_ptr + frame_len - bytes_left) % QB] = dbyte;
            bytes_left--;
            if (bytes_left == 0) begin
              frame_open = 0;
              was_empty = (rd_ptr == wr_ptr);
              wr_ptr = (wr_ptr + frame_len) % QB;
              if (was_empty) begin
                flight = frame_len > CM ? CM : frame_len;
                send_chunk();
              end
            end
          end
        end
        OP_TXDONE: begin
          rd_ptr = (rd_ptr + flight) % QB;
          if (rd_ptr == wr_ptr) len = 0;
          else if (rd_ptr > wr_ptr) len = QB - rd_ptr;
          else len = wr_ptr - rd_ptr;
          flight = len > CM ? CM : len;
          send_chunk();
        end
        default: ;
      endcase
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("Unexpected result word: result_kind %0d, tx_byte 0x%02h.",
               got.kind, got.tx_byte);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.kind == RES_ANSWER) answers++;
      else tx_bytes++;
      if (got.kind !== want.kind) begin
        $error("result_kind mismatch: expected %0h, actual %0h", want.kind, got.kind);
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted mismatch: expected %0h, actual %0h", want.accepted, got.accepted);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte mismatch: expected %0h, actual %0h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0h, actual %0h", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [OP_W-1:0] in_operation = '0;
  logic [FLEN_W-1:0] in_frame_length = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic full, empty, out_result_kind, out_accepted, out_last;
  logic [BYTE_W-1:0] out_tx_byte;

  int send_gap_pct = 0;
  int stall_pct = 0;
  ring_tracker book = new();

  framed_tx_ring_buffer_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_frame_length(in_frame_length),
    .in_data_byte   (in_data_byte),
    .empty          (empty),
    .pop            (pop),
    .out_result_kind(out_result_kind),
    .out_accepted   (out_accepted),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1200000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      book.check_word(res_t'{out_result_kind, out_accepted, out_tx_byte, out_last});
    pop <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [FLEN_W-1:0] flen,
                           input logic [BYTE_W-1:0] dbyte);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_frame_length <= flen;
    in_data_byte <= dbyte;
    do @(posedge clk); while (full);
    book.note_word(op, flen, dbyte);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (book.waiting() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int budget);
    int sent, len, free, roll, cut;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        free = book.free_bytes();
        roll = $urandom_range(99);
        if (roll < 8) len = 0;
        else if (roll < 18) len = (free <= 80) ? free : $urandom_range(1, 24);
        else if (roll < 28) len = $urandom_range(free + 1, 256);
        else if (roll < 34) len = $urandom_range(40, 120);
        else len = $urandom_range(1, 24);
        send_word(OP_APPEND, FLEN_W'(len), BYTE_W'($urandom));
        sent++;
        if (len <= free) begin
          cut = (len > 0 && $urandom_range(99) < 8) ? $urandom_range(len - 1) : len;
          for (int k = 0; k < cut; k++) begin
            send_word(OP_DATA, FLEN_W'($urandom), BYTE_W'($urandom));
            sent++;
          end
        end else begin
          repeat ($urandom_range(2)) send_word(OP_DATA, FLEN_W'($urandom), BYTE_W'($urandom));
        end
      end else if (roll < 90) begin
        send_word(OP_TXDONE, FLEN_W'($urandom), BYTE_W'($urandom));
        sent++;
      end else begin
        send_word($urandom_range(1) ? OP_DATA : OP_UNUSED, FLEN_W'($urandom),
                  BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray and unused words, a rejected frame and an empty frame on an empty queue.
    send_word(OP_DATA, 9'd0, 8'h5A);
    send_word(OP_UNUSED, 9'd0, 8'h00);
    send_word(OP_APPEND, 9'd256, 8'h00);
    send_word(OP_DATA, 9'd0, 8'h11);
    send_word(OP_APPEND, 9'd0, 8'h00);
    send_word(OP_TXDONE, 9'd0, 8'h00);
    // A short frame starts a send, then an open frame is dropped by a new append.
    send_word(OP_APPEND, 9'd3, 8'h00);
    send_word(OP_DATA, 9'd0, 8'h00);
    send_word(OP_DATA, 9'd0, 8'hFF);
    send_word(OP_DATA, 9'd0, 8'hA5);
    send_word(OP_APPEND, 9'd2, 8'h00);
    send_word(OP_DATA, 9'd0, 8'h01);
    send_word(OP_APPEND, 9'd1, 8'h00);
    send_word(OP_DATA, 9'd0, 8'h7E);
    send_word(OP_TXDONE, 9'd0, 8'h00);
    send_word(OP_TXDONE, 9'd0, 8'h00);
    send_word(OP_TXDONE, 9'd0, 8'h00);
    // An exact fit of the whole free space, dropped by a rejected append.
    send_word(OP_APPEND, 9'd255, 8'h00);
    send_word(OP_APPEND, 9'd256, 8'h00);
    send_word(OP_DATA, 9'd0, 8'h33);

    random_phase(55);
    wait_drained();
    send_gap_pct = 61;
    random_phase(55);
    wait_drained();
    send_gap_pct = 0;
    stall_pct = 61;
    random_phase(55);
    wait_drained();
    send_gap_pct = 21;
    stall_pct = 21;
    random_phase(55);

    while (book.backlog() != 0)
      send_word(OP_TXDONE, FLEN_W'($urandom), BYTE_W'($urandom));
    push <= 1'b0;
    for (int w = 0; w < 20000 && book.waiting() != 0; w++) @(posedge clk);
    repeat (64) @(posedge clk);
    if (book.waiting() != 0) begin
      $error("%0d expected result words never arrived.", book.waiting());
      book.errors++;
    end

    $display("Sent %0d words; checked %0d append answers and %0d transmitted bytes.",
             book.words_in, book.answers, book.tx_bytes);
    $display("Phases ran with no idling, sender gaps, receiver stalls and both together.");
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
